FILE: rtl/terminal_escape_sequence_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// terminal_escape_sequence_decoder_top_defines
// Assertion macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH
`define TERMINAL_ESCAPE_SEQUENCE_DECODER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TESD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define TESD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/tesd_pkg.sv
// ----------------------------------------------------------------------------
// tesd_pkg
// Types and constants for the terminal escape sequence decoder.
// ----------------------------------------------------------------------------
package tesd_pkg;
  localparam int MaxParamsDef = 16;
  localparam int TitleMaxDef = 512;
  localparam logic [15:0] ValMax = 16'hFFFF;
  localparam logic [7:0] BelByte = 8'h07;
  localparam logic [10:0] RowsReset = 11'd24;

  localparam logic [4:0] CmdUp = 5'd0, CmdDown = 5'd1, CmdRight = 5'd2, CmdLeft = 5'd3;
  localparam logic [4:0] CmdDownCol1 = 5'd4, CmdUpCol1 = 5'd5, CmdColumn = 5'd6;
  localparam logic [4:0] CmdGoto = 5'd7, CmdEraseDisp = 5'd8, CmdEraseLine = 5'd9;
  localparam logic [4:0] CmdDelLines = 5'd10, CmdDelChars = 5'd11, CmdRow = 5'd12;
  localparam logic [4:0] CmdFg = 5'd13, CmdBg = 5'd14, CmdReport = 5'd15;
  localparam logic [4:0] CmdScroll = 5'd16, CmdSave = 5'd17, CmdRestore = 5'd18;
  localparam logic [4:0] CmdKeypad = 5'd19, CmdRevLf = 5'd20;
  localparam logic [4:0] CmdTitleChar = 5'd21, CmdTitleEnd = 5'd22;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       begin_req;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic        region_active;
    logic        last;
  } out_item_t;
endpackage

FILE: rtl/terminal_escape_sequence_decoder_top.sv
// ----------------------------------------------------------------------------
// terminal_escape_sequence_decoder_top
// Decodes the bytes after ESC into terminal commands.
// ----------------------------------------------------------------------------
// A byte is taken on the accepting edge. A byte that produces one result is
// then worked in the SqWork state, in which the result is placed in the
// output register. An SGR final ('m') walks the stored parameters one per
// cycle, while the output is not stalled, through a single shared classify
// unit. The block is not ready while a byte is being worked or while a
// result beat waits to be taken. Digits are folded into the current
// parameter by one shared multiply-by-ten and saturate step. The parameter
// store is a small register file cleared with the sequence, so no clearing
// pass is needed after reset.
module terminal_escape_sequence_decoder_top #(
  parameter int MAX_PARAMS = tesd_pkg::MaxParamsDef,
  parameter int TITLE_MAX  = tesd_pkg::TitleMaxDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tesd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tesd_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [10:0]          cfg_data
);
  import tesd_pkg::*;
`include "terminal_escape_sequence_decoder_top_defines.svh"

  localparam int PW = $clog2(MAX_PARAMS);
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int TW = $clog2(TITLE_MAX + 1);

  // Phases of the escape parser.
  localparam logic [2:0] PhIdle = 3'd0, PhCsi = 3'd1, PhEcho = 3'd2;
  localparam logic [2:0] PhOsc = 3'd3, PhTitle = 3'd4;
  // Sequencer states.
  localparam logic [2:0] SqIdle = 3'd0, SqWork = 3'd1, SqSgr = 3'd2;
  localparam logic [2:0] SqOut = 3'd3, SqEnd2 = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  sq_r, sq_nxt;
  logic [15:0] pv_r [MAX_PARAMS];
  logic [CW-1:0] pcnt_r, pcnt_nxt;
  logic        indig_r, indig_nxt, skip_r, skip_nxt;
  logic        ten_r, ten_nxt;
  logic [TW-1:0] tlen_r, tlen_nxt;
  logic [10:0] rows_r;
  in_item_t    item_r;
  logic [PW-1:0] walk_r, walk_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;
  logic        pend_end_r, pend_end_nxt;
  logic        pv_we, pv_clr;
  logic [PW-1:0] pv_wa;
  logic [15:0] pv_wd;
  logic        more_hit;

  assign in_ready  = (sq_r == SqIdle) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  wire acc = in_valid && in_ready;

  // Shared digit unit: value * 10 + digit, saturating at 65535.
  logic [15:0] dig_src;
  logic [20:0] dig_sum;
  logic [15:0] dig_res;
  always_comb begin
    dig_sum = {1'b0, dig_src, 4'd0} - {1'b0, dig_src, 4'd0} + ({5'd0, dig_src} << 3)
            + ({5'd0, dig_src} << 1) + {17'd0, item_r.byte_in[3:0] - 4'd0};
    dig_res = (dig_sum > {5'd0, ValMax}) ? ValMax : dig_sum[15:0];
  end

  logic [15:0] p0, p1, pw;
  assign p0 = pv_r[0];
  assign p1 = pv_r[1];
  assign pw = pv_r[walk_r];

  function automatic out_item_t mk(input logic [4:0] c, input logic [15:0] a,
                                   input logic [15:0] b, input logic r);
    out_item_t o;
    o.command = c; o.first_value = a; o.second_value = b;
    o.region_active = r; o.last = 1'b1;
    return o;
  endfunction

  logic [15:0] cnt1, rows16, rend, rstart;
  logic [7:0]  c;
  logic        digit;
  always_comb begin
    c = item_r.byte_in;
    digit = (c >= "0") && (c <= "9");
    cnt1 = (pcnt_r == '0 || p0 == 16'd0) ? 16'd1 : p0;
    rows16 = (rows_r == 11'd0) ? 16'd1 : {5'd0, rows_r};
    rstart = (p0 != 16'd0) ? p0 - 16'd1 : 16'd0;
    rend = (p1 != 16'd0) ? p1 - 16'd1 : rows16 - 16'd1;
    if (rend >= rows16) rend = rows16 - 16'd1;
  end

  always_comb begin
    phase_nxt = phase_r; sq_nxt = sq_r; pcnt_nxt = pcnt_r; indig_nxt = indig_r;
    skip_nxt = skip_r; ten_nxt = ten_r; tlen_nxt = tlen_r; walk_nxt = walk_r;
    ov_nxt = ov_r; od_nxt = od_r; pend_end_nxt = pend_end_r;
    pv_we = 1'b0; pv_clr = 1'b0; pv_wa = '0; pv_wd = '0; dig_src = pv_r[0];
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (sq_r)
      SqIdle: begin
        if (acc) sq_nxt = SqWork;
      end
      SqWork: begin
        sq_nxt = SqIdle;
        if (item_r.begin_req) begin
          pv_clr = 1'b1; pcnt_nxt = '0; indig_nxt = 1'b0; skip_nxt = 1'b0;
          ten_nxt = 1'b0; tlen_nxt = '0; phase_nxt = PhIdle;
          case (c)
            "[": phase_nxt = PhCsi;
            "]": phase_nxt = PhOsc;
            "7": begin ov_nxt = 1'b1; od_nxt = mk(CmdSave, 16'd0, 16'd0, 1'b0); end
            "8": begin ov_nxt = 1'b1; od_nxt = mk(CmdRestore, 16'd0, 16'd0, 1'b0); end
            "=": begin ov_nxt = 1'b1; od_nxt = mk(CmdKeypad, 16'd1, 16'd0, 1'b0); end
            ">": begin ov_nxt = 1'b1; od_nxt = mk(CmdKeypad, 16'd0, 16'd0, 1'b0); end
            "M": begin ov_nxt = 1'b1; od_nxt = mk(CmdRevLf, 16'd0, 16'd0, 1'b0); end
            default: ;
          endcase
        end else begin
          case (phase_r)
            PhCsi: begin
              if (digit) begin
                logic [CW-1:0] pc;
                logic sk;
                pc = pcnt_r; sk = skip_r;
                if (!indig_r) begin
                  indig_nxt = 1'b1;
                  if (pcnt_r < CW'(MAX_PARAMS)) begin
                    pc = pcnt_r + 1'b1; sk = 1'b0;
                  end else sk = 1'b1;
                end
                pcnt_nxt = pc; skip_nxt = sk;
                if (!sk && pc != '0) begin
                  pv_wa = PW'(pc - 1'b1);
                  dig_src = (indig_r) ? pv_r[pv_wa] : pv_r[pv_wa];
                  pv_we = 1'b1; pv_wd = dig_res;
                end
              end else if (c == ";") begin
                if (pcnt_r < CW'(MAX_PARAMS)) begin
                  pv_we = 1'b1; pv_wa = PW'(pcnt_r); pv_wd = 16'd0;
                end
                indig_nxt = 1'b0; skip_nxt = 1'b0;
              end else if (c != "?") begin
                phase_nxt = (c == "[") ? PhEcho : PhIdle;
                case (c)
                  "A": begin ov_nxt = 1'b1; od_nxt = mk(CmdUp, cnt1, 16'd0, 1'b0); end
                  "B": begin ov_nxt = 1'b1; od_nxt = mk(CmdDown, cnt1, 16'd0, 1'b0); end
                  "C": begin ov_nxt = 1'b1; od_nxt = mk(CmdRight, cnt1, 16'd0, 1'b0); end
                  "D": begin ov_nxt = 1'b1; od_nxt = mk(CmdLeft, cnt1, 16'd0, 1'b0); end
                  "E": begin ov_nxt = 1'b1; od_nxt = mk(CmdDownCol1, cnt1, 16'd0, 1'b0); end
                  "F": begin ov_nxt = 1'b1; od_nxt = mk(CmdUpCol1, cnt1, 16'd0, 1'b0); end
                  "G": begin ov_nxt = 1'b1; od_nxt = mk(CmdColumn, cnt1, 16'd0, 1'b0); end
                  "M": begin ov_nxt = 1'b1; od_nxt = mk(CmdDelLines, cnt1, 16'd0, 1'b0); end
                  "P": begin ov_nxt = 1'b1; od_nxt = mk(CmdDelChars, cnt1, 16'd0, 1'b0); end
                  "d": begin ov_nxt = 1'b1; od_nxt = mk(CmdRow, cnt1, 16'd0, 1'b0); end
                  "H": begin
                    ov_nxt = 1'b1;
                    od_nxt = mk(CmdGoto, (p1 != 16'd0) ? p1 : 16'd1,
                                (p0 != 16'd0) ? p0 : 16'd1, 1'b0);
                  end
                  "J", "K": begin
                    if (pcnt_r == '0 || p0 <= 16'd2) begin
                      ov_nxt = 1'b1;
                      od_nxt = mk((c == "J") ? CmdEraseDisp : CmdEraseLine,
                                  (pcnt_r == '0) ? 16'd0 : p0, 16'd0, 1'b0);
                    end
                  end
                  "n": begin
                    if (p0 == 16'd6) begin
                      ov_nxt = 1'b1; od_nxt = mk(CmdReport, 16'd0, 16'd0, 1'b0);
                    end
                  end
                  "r": begin
                    ov_nxt = 1'b1;
                    od_nxt = mk(CmdScroll, rstart, rend,
                                !(pcnt_r == '0 || (p0 == 16'd1 && p1 == rows16)));
                  end
                  "m": begin
                    if (pcnt_r == '0) begin
                      ov_nxt = 1'b1; od_nxt = mk(CmdFg, 16'd7, 16'd0, 1'b0);
                      od_nxt.last = 1'b0;
                      pend_end_nxt = 1'b0; sq_nxt = SqEnd2;
                    end else begin
                      walk_nxt = '0; sq_nxt = SqSgr;
                    end
                  end
                  default: ;
                endcase
              end
            end
            PhEcho: phase_nxt = PhIdle;
            PhOsc: begin
              if (digit) begin
                pcnt_nxt = CW'(1); dig_src = pv_r[0];
                pv_we = 1'b1; pv_wa = '0; pv_wd = dig_res;
              end else if (c == ";" && pcnt_r != '0) begin
                phase_nxt = PhTitle; ten_nxt = (p0 <= 16'd2); tlen_nxt = '0;
              end else phase_nxt = PhIdle;
            end
            PhTitle: begin
              if (c == BelByte) begin
                phase_nxt = PhIdle;
                if (ten_r) begin
                  ov_nxt = 1'b1; od_nxt = mk(CmdTitleEnd, 16'd0, 16'd0, 1'b0);
                end
              end else begin
                tlen_nxt = tlen_r + 1'b1;
                if (tlen_nxt >= TW'(TITLE_MAX)) begin
                  phase_nxt = PhIdle;
                  if (ten_r) begin
                    ov_nxt = 1'b1; od_nxt = mk(CmdTitleChar, {8'd0, c}, 16'd0, 1'b0);
                    od_nxt.last = 1'b0; sq_nxt = SqEnd2; pend_end_nxt = 1'b1;
                  end
                end else if (ten_r) begin
                  ov_nxt = 1'b1; od_nxt = mk(CmdTitleChar, {8'd0, c}, 16'd0, 1'b0);
                end
              end
            end
            default: phase_nxt = PhIdle;
          endcase
        end
      end
      SqEnd2: begin
        // Second beat of a two-result byte, after the first is taken.
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; sq_nxt = SqIdle;
          od_nxt = pend_end_r ? mk(CmdTitleEnd, 16'd0, 16'd0, 1'b0)
                              : mk(CmdBg, 16'd0, 16'd0, 1'b0);
        end
      end
      SqSgr: begin
        // One parameter classified per cycle while the output is not stalled.
        // A beat carries last only when no later stored parameter yields a colour.
        if (!ov_r || out_ready) begin
          logic hit;
          logic [4:0] cm;
          logic [15:0] v;
          hit = 1'b1; cm = CmdFg; v = 16'd0;
          if (pw == 16'd0 || pw == 16'd39) v = 16'd7;
          else if (pw >= 16'd30 && pw <= 16'd37) v = pw - 16'd30;
          else if (pw >= 16'd40 && pw <= 16'd47) begin cm = CmdBg; v = pw - 16'd40; end
          else if (pw == 16'd49) cm = CmdBg;
          else hit = 1'b0;
          if (hit) begin
            ov_nxt = 1'b1; od_nxt = mk(cm, v, 16'd0, 1'b0);
            od_nxt.last = !more_hit;
          end
          if ({1'b0, walk_r} + 1'b1 >= (CW+1)'(pcnt_r)) begin
            sq_nxt = SqOut;
          end else walk_nxt = walk_r + 1'b1;
        end
      end
      default: sq_nxt = SqIdle;
    endcase
    // SqOut: nothing, last marking is handled by the scan ahead below.
    if (sq_r == SqOut) sq_nxt = SqIdle;
  end

  // Last marking for the SGR walk: a beat carries last when no later stored
  // parameter up to param_count yields a colour. Computed by a small scan
  // over the remaining entries, MAX_PARAMS wide and independent per entry.
  always_comb begin
    more_hit = 1'b0;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      if (PW'(i) > walk_r && CW'(i) < pcnt_r &&
          (pv_r[i] == 16'd0 || pv_r[i] == 16'd39 || pv_r[i] == 16'd49 ||
           (pv_r[i] >= 16'd30 && pv_r[i] <= 16'd37) ||
           (pv_r[i] >= 16'd40 && pv_r[i] <= 16'd47)))
        more_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhIdle; sq_r <= SqIdle; pcnt_r <= '0; indig_r <= 1'b0;
      skip_r <= 1'b0; ten_r <= 1'b0; tlen_r <= '0; walk_r <= '0; ov_r <= 1'b0;
      pend_end_r <= 1'b0; rows_r <= RowsReset;
      for (int i = 0; i < MAX_PARAMS; i++) pv_r[i] <= 16'd0;
    end else begin
      phase_r <= phase_nxt; sq_r <= sq_nxt; pcnt_r <= pcnt_nxt;
      indig_r <= indig_nxt; skip_r <= skip_nxt; ten_r <= ten_nxt;
      tlen_r <= tlen_nxt; walk_r <= walk_nxt; ov_r <= ov_nxt;
      pend_end_r <= pend_end_nxt;
      if (cfg_valid && cfg_ready) rows_r <= cfg_data;
      if (pv_clr) begin
        for (int i = 0; i < MAX_PARAMS; i++) pv_r[i] <= 16'd0;
      end else if (pv_we) pv_r[pv_wa] <= pv_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) item_r <= in_data;
    od_r <= od_nxt;
  end

  `TESD_ASSERT_IMP(a_no_accept_busy, sq_r != SqIdle, !in_ready, "accepted while busy")
  `TESD_ASSERT_NXT(a_accept_work, acc, sq_r == SqWork, "accept did not start work")
  `TESD_ASSERT_IMP(a_pcnt_range, 1'b1, pcnt_r <= CW'(MAX_PARAMS), "param count overflow")
  `TESD_ASSERT_IMP(a_title_phase, ten_r && phase_r == PhTitle, tlen_r < TW'(TITLE_MAX),
                   "title length overflow")
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal escape sequence decoder. Byte streams
// (well-formed CSI, OSC and single escapes with random content, plus noise)
// go in; each result beat is compared against a behavioral decoder model.
// ----------------------------------------------------------------------------
module tb_top;
  import tesd_pkg::*;

  // Behavioral copy of the decoder. It keeps its own parse state and row
  // setting, and queues the command beats that each accepted byte yields.
  class cmd_scoreboard;
    localparam int NPAR = MaxParamsDef;
    typedef enum logic [2:0] {PIdle, PCsi, PEcho, POsc, PTitle} parse_t;
    parse_t            ph;
    logic [16:0]       pv[NPAR];
    int                pcnt;
    bit                digits, skipping, live;
    int                tlen;
    int                rows;
    out_item_t         pending[$];
    int                errors;
    out_item_t         burst[$];

    function new();
      rows = RowsReset;
      ph = PIdle;
      errors = 0;
      wipe();
      live = 0;
      tlen = 0;
    endfunction

    function void wipe();
      foreach (pv[i]) pv[i] = 0;
      pcnt = 0;
      digits = 0;
      skipping = 0;
    endfunction

    function void push(logic [4:0] c, logic [15:0] a, logic [15:0] b, logic r);
      out_item_t o;
      o.command = c;
      o.first_value = a;
      o.second_value = b;
      o.region_active = r;
      o.last = 0;
      burst.push_back(o);
    endfunction

    function logic [16:0] fold(logic [16:0] v, logic [7:0] c);
      logic [31:0] t;
      t = v * 10 + (c - "0");
      return (t > ValMax) ? ValMax : t[16:0];
    endfunction

    function logic [15:0] cnt1();
      return (pcnt == 0 || pv[0] == 0) ? 16'd1 : pv[0][15:0];
    endfunction

    function void final_byte(logic [7:0] c);
      logic [16:0] p0, p1, md, st, en, rr, v;
      p0 = pv[0];
      p1 = pv[1];
      case (c)
        "A": push(CmdUp, cnt1(), 0, 0);
        "B": push(CmdDown, cnt1(), 0, 0);
        "C": push(CmdRight, cnt1(), 0, 0);
        "D": push(CmdLeft, cnt1(), 0, 0);
        "E": push(CmdDownCol1, cnt1(), 0, 0);
        "F": push(CmdUpCol1, cnt1(), 0, 0);
        "G": push(CmdColumn, cnt1(), 0, 0);
        "H": push(CmdGoto, p1 ? p1 : 1, p0 ? p0 : 1, 0);
        "J", "K": begin
          md = pcnt ? p0 : 0;
          if (md <= 2) push(c == "J" ? CmdEraseDisp : CmdEraseLine, md, 0, 0);
        end
        "M": push(CmdDelLines, cnt1(), 0, 0);
        "P": push(CmdDelChars, cnt1(), 0, 0);
        "d": push(CmdRow, cnt1(), 0, 0);
        "m": begin
          if (pcnt == 0) begin
            push(CmdFg, 7, 0, 0);
            push(CmdBg, 0, 0, 0);
          end
          for (int i = 0; i < pcnt; i++) begin
            v = pv[i];
            if (v == 0 || v == 39) push(CmdFg, 7, 0, 0);
            else if (v >= 30 && v <= 37) push(CmdFg, v - 30, 0, 0);
            else if (v >= 40 && v <= 47) push(CmdBg, v - 40, 0, 0);
            else if (v == 49) push(CmdBg, 0, 0, 0);
          end
        end
        "n": if (p0 == 6) push(CmdReport, 0, 0, 0);
        "r": begin
          rr = rows ? rows : 1;
          st = p0 ? p0 - 1 : 0;
          en = p1 ? p1 - 1 : rr - 1;
          if (en >= rr) en = rr - 1;
          push(CmdScroll, st, en,
               !(pcnt == 0 || (p0 == 1 && p1 == rr)));
        end
        default: ;
      endcase
    endfunction

    // Notes one accepted input beat and queues the results it causes.
    function void note_byte(in_item_t it);
      logic [7:0] c;
      c = it.byte_in;
      burst.delete();
      if (it.begin_req) begin
        wipe();
        live = 0;
        tlen = 0;
        ph = PIdle;
        case (c)
          "[": ph = PCsi;
          "]": ph = POsc;
          "7": push(CmdSave, 0, 0, 0);
          "8": push(CmdRestore, 0, 0, 0);
          "=": push(CmdKeypad, 1, 0, 0);
          ">": push(CmdKeypad, 0, 0, 0);
          "M": push(CmdRevLf, 0, 0, 0);
          default: ;
        endcase
      end else begin
        case (ph)
          PCsi: begin
            if (c >= "0" && c <= "9") begin
              if (!digits) begin
                digits = 1;
                if (pcnt < NPAR) begin
                  pcnt++;
                  skipping = 0;
                end else begin
                  skipping = 1;
                end
              end
              if (!skipping && pcnt > 0) pv[pcnt-1] = fold(pv[pcnt-1], c);
            end else if (c == ";") begin
              if (pcnt < NPAR) pv[pcnt] = 0;
              digits = 0;
              skipping = 0;
            end else if (c != "?") begin
              ph = (c == "[") ? PEcho : PIdle;
              final_byte(c);
            end
          end
          POsc: begin
            if (c >= "0" && c <= "9") begin
              pcnt = 1;
              pv[0] = fold(pv[0], c);
            end else if (c == ";" && pcnt != 0) begin
              ph = PTitle;
              live = pv[0] <= 2;
              tlen = 0;
            end else begin
              ph = PIdle;
            end
          end
          PTitle: begin
            if (c == BelByte) begin
              if (live) push(CmdTitleEnd, 0, 0, 0);
              ph = PIdle;
            end else begin
              if (live) push(CmdTitleChar, c, 0, 0);
              tlen++;
              if (tlen >= TitleMaxDef) begin
                if (live) push(CmdTitleEnd, 0, 0, 0);
                ph = PIdle;
              end
            end
          end
          default: ph = PIdle;
        endcase
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    // Compares one result beat against the oldest pending command.
    function void check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        $error("unexpected result beat: command %0d", got.command);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.command !== w.command) begin
        $error("command: expected %0d, got %0d", w.command, got.command);
        errors++;
      end
      if (got.first_value !== w.first_value) begin
        $error("first_value: expected %0d, got %0d", w.first_value, got.first_value);
        errors++;
      end
      if (got.second_value !== w.second_value) begin
        $error("second_value: expected %0d, got %0d", w.second_value, got.second_value);
        errors++;
      end
      if (got.region_active !== w.region_active) begin
        $error("region_active: expected %0d, got %0d", w.region_active,
               got.region_active);
        errors++;
      end
      if (got.last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  in_item_t    in_data;
  logic        out_valid, out_ready;
  out_item_t   out_data;
  logic        cfg_valid, cfg_ready;
  logic [10:0] cfg_data;

  cmd_scoreboard sb;
  int  idle_pct;   // chance in percent that either side idles in a cycle
  longint cycles;
  localparam longint CycleLimit = 400000;

  terminal_escape_sequence_decoder_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A correct run needs only a small fraction of this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls on out_ready, every accepted beat is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Sends one byte; the sender may idle first. Valid stays up until taken,
  // and is only dropped when the sender idles or stops.
  task automatic send(input logic [7:0] b, input logic bgn);
    in_item_t it;
    it.byte_in = b;
    it.begin_req = bgn;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(it);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i], i == 0);
  endtask

  // Waits until all predicted results are in, then lets the block settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_rows(input logic [10:0] r);
    drain();
    cfg_valid <= 1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.rows = r;
  endtask

  // Random CSI parameter text, mostly short small numbers with some extremes.
  function automatic string rand_params();
    string s;
    int n;
    s = "";
    n = $urandom_range(99) < 10 ? $urandom_range(20) : $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: s = {s, $sformatf("%0d", $urandom_range(99999))};
        1: s = {s, ""};
        2: s = {s, $sformatf("%0d", 30 + $urandom_range(19))};
        3: s = {s, "0"};
        4: s = {s, "?"};
        default: s = {s, $sformatf("%0d", $urandom_range(30))};
      endcase
      if (i != n - 1) s = {s, ";"};
    end
    return s;
  endfunction

  task automatic random_sequence();
    string finals;
    string s;
    int k;
    finals = "ABCDEFGHJKMPdmnr[xq";
    k = $urandom_range(99);
    if (k < 55) begin
      s = {"[", rand_params()};
      s = {s, string'(finals[$urandom_range(finals.len() - 1)])};
      send_str(s);
      if (s[s.len()-1] == "[") send($urandom_range(255), 0);
    end else if (k < 70) begin
      send_str($sformatf("]%0d;", $urandom_range(99) < 80 ? $urandom_range(2)
                                                           : $urandom_range(9)));
      repeat ($urandom_range(6)) send($urandom_range(8, 255), 0);
      if ($urandom_range(3) != 0) send(BelByte, 0);
    end else if (k < 85) begin
      s = "78=>M";
      send(s[$urandom_range(4)], 1);
    end else begin
      // Noise: arbitrary bytes with arbitrary begin flags.
      send($urandom_range(255), $urandom_range(1));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    idle_pct = 34;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: each single escape, the finals A-D, H, J, K, m, n, r, q and [, defaults, extremes.
    send_str("7"); send_str("8"); send_str("="); send_str(">"); send_str("M");
    send_str("[A"); send_str("[0B"); send_str("[65535;99999C");
    send_str("[;5D"); send_str("[12;40H"); send_str("[3J"); send_str("[2K");
    send_str("[m"); send_str("[0;31;47;39;49;38;1m"); send_str("[6n");
    send_str("[r"); send_str("[1;24r"); send_str("[5;300r");
    send_str("[?1q"); send_str("[[");
    send(8'hFF, 0);
    send_str("[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;31;42m");
    send_str("]2;");
    send(8'h00, 0); send(8'hFE, 0); send(BelByte, 0);
    send_str("]5;"); send("z", 0); send(BelByte, 0);
    send_str("]x");
    send(8'h41, 0);
    // A title that hits the length cap, sent as one long stretch in which
    // neither side idles.
    idle_pct = 0;
    send_str("]0;");
    for (int i = 0; i < TitleMaxDef; i++) send(8'h20 + i % 90, 0);
    idle_pct = 34;

    // Configuration extremes, each followed by scroll region checks.
    write_rows(11'd1);
    send_str("[r"); send_str("[1;1r"); send_str("[3;9r");
    write_rows(11'd1024);
    send_str("[r"); send_str("[1;1024r"); send_str("[2;2000r");
    write_rows(11'd0);
    send_str("[r"); send_str("[1;1r");
    write_rows(11'h7FF);
    send_str("[4;2047r");

    // Random part with idling on both sides.
    for (int i = 0; i < 40; i++) begin
      random_sequence();
      if (i == 20) begin
        drain();      // hold off until every command has come out
        write_rows(11'($urandom_range(1, 1024)));
      end
    end
    write_rows(11'd24);
    for (int i = 0; i < 8; i++) random_sequence();

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
